[hw/rtl/bstl_pkg.sv]
// Package for the byte stream token lexer.
// Holds the lexer mode, token kind and operation codes, the token record and the
// character constants. Depends on nothing.
package bstl_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2
  } lex_mode_t;

  typedef enum logic [1:0] {
    KIND_INT    = 2'd0,
    KIND_PLEASE = 2'd1,
    KIND_WHAT   = 2'd2,
    KIND_OP     = 2'd3
  } tok_kind_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_DIV = 3'd2,
    OP_MUL = 3'd3,
    OP_EQ  = 3'd4
  } op_sym_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [31:0] value;
    logic        overflow;
    op_sym_t     op;
    logic        run_last;
  } token_t;

  typedef struct packed {
    logic   vld;
    token_t tok;
  } tok_slot_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_EQUAL = 8'h3d;

  localparam logic [2:0] LEN_PLEASE = 3'd6;
  localparam logic [2:0] LEN_WHAT   = 3'd4;
  localparam logic [2:0] LEN_MAX    = 3'd7;

  // Expected letter of "please" at a word position.
  function automatic logic [7:0] please_char(input logic [2:0] pos);
    case (pos)
      3'd0:    please_char = 8'h70;
      3'd1:    please_char = 8'h6c;
      3'd2:    please_char = 8'h65;
      3'd3:    please_char = 8'h61;
      3'd4:    please_char = 8'h73;
      3'd5:    please_char = 8'h65;
      default: please_char = 8'h00;
    endcase
  endfunction

  // Expected letter of "what" at a word position.
  function automatic logic [7:0] what_char(input logic [2:0] pos);
    case (pos)
      3'd0:    what_char = 8'h77;
      3'd1:    what_char = 8'h68;
      3'd2:    what_char = 8'h61;
      3'd3:    what_char = 8'h74;
      default: what_char = 8'h00;
    endcase
  endfunction

endpackage

[hw/rtl/bstl_in_if.sv]
// Input channel of the byte stream token lexer: one text byte per transaction.
// Standalone interface, no package dependency.
interface bstl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       text_end;

  modport source (output valid, output char_byte, output text_end, input ready);
  modport sink (input valid, input char_byte, input text_end, output ready);
endinterface

[hw/rtl/bstl_out_if.sv]
// Result channel of the byte stream token lexer: one token per transaction.
// Standalone interface, no package dependency.
interface bstl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [31:0] number_value;
  logic        number_overflow;
  logic [2:0]  op_symbol;
  logic        run_last;

  modport source (output valid, output token_kind, output number_value,
                  output number_overflow, output op_symbol, output run_last,
                  input ready);
  modport sink (input valid, input token_kind, input number_value,
                input number_overflow, input op_symbol, input run_last,
                output ready);
endinterface

[hw/rtl/bstl_lexer.sv]
// Lexer state registers and the per-byte update, producing up to two tokens.
// Depends on bstl_pkg.
module bstl_lexer #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        char_byte,
  input  logic              text_end,
  output bstl_pkg::token_t  tok0,
  output bstl_pkg::token_t  tok1,
  output logic [1:0]        tok_cnt
);
  import bstl_pkg::*;

  localparam logic [NUMBER_WIDTH-1:0] ACC_MAX = '1;

  lex_mode_t               mode_r, mode_nxt;
  logic [NUMBER_WIDTH-1:0] acc_r, acc_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [2:0]              len_r, len_nxt;
  logic                    pa_r, pa_nxt;
  logic                    wa_r, wa_nxt;

  logic                    is_digit, is_letter, is_op;
  op_sym_t                 op_code;
  logic [3:0]              digit;
  logic [NUMBER_WIDTH-1:0] base_acc;
  logic                    base_ovf;
  logic [NUMBER_WIDTH+3:0] prod;
  logic [NUMBER_WIDTH-1:0] add_acc;
  logic                    add_ovf;
  logic [2:0]              base_len;
  logic                    base_pa, base_wa;
  logic                    add_pa, add_wa;
  logic [2:0]              add_len;
  tok_slot_t               close_cur, slot_a, slot_b;

  // Token that closing a run with the given state produces, if any.
  function automatic tok_slot_t close_run(
    input lex_mode_t mode, input logic [NUMBER_WIDTH-1:0] acc, input logic ovf,
    input logic [2:0] len, input logic pa, input logic wa);
    tok_slot_t                s;
    logic [NUMBER_WIDTH+31:0] ext;
    ext = {32'b0, acc};
    s.vld          = 1'b0;
    s.tok.kind     = KIND_INT;
    s.tok.value    = '0;
    s.tok.overflow = 1'b0;
    s.tok.op       = OP_ADD;
    s.tok.run_last = 1'b0;
    case (mode)
      MODE_NUM: begin
        s.vld          = 1'b1;
        s.tok.value    = ext[31:0];
        s.tok.overflow = ovf;
      end
      MODE_WORD: begin
        if (pa && len == LEN_PLEASE) begin
          s.vld      = 1'b1;
          s.tok.kind = KIND_PLEASE;
        end else if (wa && len == LEN_WHAT) begin
          s.vld      = 1'b1;
          s.tok.kind = KIND_WHAT;
        end
      end
      default: s.vld = 1'b0;
    endcase
    return s;
  endfunction

  always_comb begin
    is_digit  = char_byte inside {[CH_ZERO:CH_NINE]};
    is_letter = char_byte inside {[CH_LOW_A:CH_LOW_Z]};
    is_op     = 1'b1;
    case (char_byte)
      CH_PLUS:  op_code = OP_ADD;
      CH_MINUS: op_code = OP_SUB;
      CH_SLASH: op_code = OP_DIV;
      CH_STAR:  op_code = OP_MUL;
      CH_EQUAL: op_code = OP_EQ;
      default: begin
        op_code = OP_ADD;
        is_op   = 1'b0;
      end
    endcase
    digit = 4'(char_byte - CH_ZERO);

    close_cur = close_run(mode_r, acc_r, ovf_r, len_r, pa_r, wa_r);

    // Number run: continue or start fresh, then scale by ten and add the digit.
    base_acc = (mode_r == MODE_NUM) ? acc_r : '0;
    base_ovf = (mode_r == MODE_NUM) ? ovf_r : 1'b0;
    prod     = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1)
               + (NUMBER_WIDTH+4)'(digit);
    if (|prod[NUMBER_WIDTH+3:NUMBER_WIDTH]) begin
      add_acc = ACC_MAX;
      add_ovf = 1'b1;
    end else begin
      add_acc = prod[NUMBER_WIDTH-1:0];
      add_ovf = base_ovf;
    end

    // Word run: track keyword match progress by position.
    base_len = (mode_r == MODE_WORD) ? len_r : 3'd0;
    base_pa  = (mode_r == MODE_WORD) ? pa_r : 1'b1;
    base_wa  = (mode_r == MODE_WORD) ? wa_r : 1'b1;
    add_pa   = base_pa && base_len < LEN_PLEASE && char_byte == please_char(base_len);
    add_wa   = base_wa && base_len < LEN_WHAT && char_byte == what_char(base_len);
    add_len  = (base_len < LEN_MAX) ? base_len + 3'd1 : base_len;

    mode_nxt = MODE_IDLE;
    acc_nxt  = '0;
    ovf_nxt  = 1'b0;
    len_nxt  = 3'd0;
    pa_nxt   = 1'b1;
    wa_nxt   = 1'b1;
    slot_a   = close_cur;
    slot_b   = '0;

    if (is_digit) begin
      if (mode_r == MODE_NUM) slot_a.vld = 1'b0;
      if (text_end) begin
        slot_b = close_run(MODE_NUM, add_acc, add_ovf, 3'd0, 1'b0, 1'b0);
      end else begin
        mode_nxt = MODE_NUM;
        acc_nxt  = add_acc;
        ovf_nxt  = add_ovf;
      end
    end else if (is_letter) begin
      if (mode_r == MODE_WORD) slot_a.vld = 1'b0;
      if (text_end) begin
        slot_b = close_run(MODE_WORD, '0, 1'b0, add_len, add_pa, add_wa);
      end else begin
        mode_nxt = MODE_WORD;
        len_nxt  = add_len;
        pa_nxt   = add_pa;
        wa_nxt   = add_wa;
      end
    end else begin
      slot_b.vld      = is_op;
      slot_b.tok.kind = KIND_OP;
      slot_b.tok.op   = op_code;
    end

    // Pack the valid tokens to the front and mark the final one.
    tok0    = slot_a.vld ? slot_a.tok : slot_b.tok;
    tok1    = slot_b.tok;
    tok_cnt = {1'b0, slot_a.vld} + {1'b0, slot_b.vld};
    tok0.run_last = (tok_cnt == 2'd1);
    tok1.run_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      ovf_r  <= 1'b0;
      len_r  <= 3'd0;
      pa_r   <= 1'b1;
      wa_r   <= 1'b1;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
      len_r  <= len_nxt;
      pa_r   <= pa_nxt;
      wa_r   <= wa_nxt;
    end
  end

endmodule

[hw/rtl/bstl_tok_fifo.sv]
// Four-entry token queue taking up to two tokens per cycle and giving one.
// Depends on bstl_pkg.
module bstl_tok_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [1:0]        push_cnt,
  input  bstl_pkg::token_t  push_tok0,
  input  bstl_pkg::token_t  push_tok1,
  output logic              space_two,
  output logic              pop_valid,
  input  logic              pop_ready,
  output bstl_pkg::token_t  pop_tok
);
  import bstl_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  token_t          mem_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic [1:0]      n_in;
  logic            pop;

  always_comb begin
    n_in      = push ? push_cnt : 2'd0;
    pop       = pop_valid && pop_ready;
    wp_nxt    = wp_r + AW'(n_in);
    rp_nxt    = rp_r + AW'(pop);
    cnt_nxt   = cnt_r + (AW+1)'(n_in) - (AW+1)'(pop);
    space_two = cnt_r <= (AW+1)'(DEPTH - 2);
    pop_valid = cnt_r != '0;
    pop_tok   = mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) mem_r[wp_r] <= push_tok0;
    if (n_in == 2'd2) mem_r[wp_r + AW'(1)] <= push_tok1;
  end

endmodule

[hw/rtl/byte_stream_token_lexer_core.sv]
// Top level of the byte stream token lexer.
// Depends on bstl_pkg, bstl_in_if, bstl_out_if, bstl_lexer and bstl_tok_fifo.

// Byte stream token lexer. Takes one text byte per transaction on in_chan and
// delivers tokens on out_chan: digit runs become integer tokens (saturated at
// 2^NUMBER_WIDTH-1 with number_overflow set, low 32 bits shown), lower-case runs
// spelling "please" or "what" become keyword tokens, and + - / * = become
// operation tokens. Any other byte closes the current run and is dropped; a byte
// with text_end set closes any open run after it is handled. One byte may yield
// zero, one or two tokens, and run_last marks the final token of each byte.
// Throughput is one byte per cycle while tokens are taken as fast as they come;
// the output side drains one token per cycle, so bytes that yield two tokens
// stall the input once the four-entry token queue holds more than two. A byte is
// lexed as it is accepted and its tokens are registered into the token queue.
module byte_stream_token_lexer_core #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  bstl_in_if.sink    in_chan,
  bstl_out_if.source out_chan
);
  import bstl_pkg::*;

  logic       in_fire;
  token_t     tok0, tok1, head_tok;
  logic [1:0] tok_cnt;
  logic       space_two;

  // Accept a byte whenever the queue can absorb both possible tokens.
  assign in_chan.ready = space_two;
  assign in_fire       = in_chan.valid && space_two;

  // Lex the byte against the current run state.
  bstl_lexer #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .char_byte (in_chan.char_byte),
    .text_end  (in_chan.text_end),
    .tok0      (tok0),
    .tok1      (tok1),
    .tok_cnt   (tok_cnt)
  );

  // Hold tokens until the sink takes them, one transaction per cycle.
  bstl_tok_fifo u_tok_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_cnt  (tok_cnt),
    .push_tok0 (tok0),
    .push_tok1 (tok1),
    .space_two (space_two),
    .pop_valid (out_chan.valid),
    .pop_ready (out_chan.ready),
    .pop_tok   (head_tok)
  );

  assign out_chan.token_kind      = head_tok.kind;
  assign out_chan.number_value    = head_tok.value;
  assign out_chan.number_overflow = head_tok.overflow;
  assign out_chan.op_symbol       = head_tok.op;
  assign out_chan.run_last        = head_tok.run_last;

endmodule
